[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TCPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tcpq_pkg.sv]
// types and constants of the two-class priority queue
`default_nettype none

package tcpq_pkg;

	localparam int ID_W  = 16;
	localparam int REM_W = 5;

	typedef enum logic [1:0] {
		MODE_REGISTER = 2'd0,
		MODE_CALL     = 2'd1,
		MODE_CANCEL   = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_REGISTERED = 3'd0,
		ST_FULL       = 3'd1,
		ST_CANCELLED  = 3'd2,
		ST_NOT_FOUND  = 3'd3,
		ST_SERVED     = 3'd4,
		ST_NONE       = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_REG  = 2'd1,
		S_CALL = 2'd2,
		S_SCAN = 2'd3
	} state_t;

	typedef struct packed {
		mode_t             mode;
		logic [ID_W-1:0]   ticket_id;
		logic              express;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   served_id;
		logic              served_fast;
		logic [REM_W-1:0]  remaining;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic    load;
		logic    insert;
		logic    remove;
		logic    idx_inc;
		logic    emit;
		status_t code;
		logic    last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_end;
		logic match;
		logic batch_last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

[rtl/tcpq_datapath.sv]
// queue storage, counters, scan index and result register
`default_nettype none

module tcpq_datapath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int BATCH_SIZE  = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire tcpq_pkg::req_t    in_data,
	input  wire tcpq_pkg::ctrl_cmd_t cmd,
	output tcpq_pkg::dp_stat_t     stat,
	output logic                   out_valid,
	input  wire                    out_ready,
	output tcpq_pkg::rsp_t         out_data
);

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int BAT_W = $clog2(BATCH_SIZE + 1);

	tcpq_pkg::req_t                req_q;
	logic [tcpq_pkg::ID_W-1:0]     ids_q [QUEUE_DEPTH];
	logic                          fast_q [QUEUE_DEPTH];
	logic [OCC_W-1:0]              occ_q;
	logic [OCC_W-1:0]              fcnt_q;
	logic [OCC_W-1:0]              idx_q;
	logic [BAT_W-1:0]              batch_q;
	logic                          out_valid_q;
	tcpq_pkg::rsp_t                out_q;

	logic [IDX_W-1:0]              sel;
	logic [tcpq_pkg::ID_W-1:0]     sel_id;
	logic                          sel_fast;
	logic [OCC_W-1:0]              ipos;
	logic [OCC_W-1:0]              occ_d;
	logic                          take_entry;

	assign sel      = idx_q[IDX_W-1:0];
	assign sel_id   = ids_q[sel];
	assign sel_fast = fast_q[sel];
	assign ipos     = req_q.express ? fcnt_q : occ_q;

	always_comb begin
		if (cmd.insert) begin
			occ_d = occ_q + OCC_W'(1);
		end else if (cmd.remove) begin
			occ_d = occ_q - OCC_W'(1);
		end else begin
			occ_d = occ_q;
		end
	end

	assign stat.full       = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign stat.empty      = (occ_q == '0);
	assign stat.scan_end   = (idx_q == occ_q);
	assign stat.match      = (sel_id == req_q.ticket_id);
	assign stat.batch_last = (batch_q == BAT_W'(BATCH_SIZE - 1)) || (occ_q == OCC_W'(1));
	assign stat.out_free   = !out_valid_q || out_ready;

	// request latch, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data;
		end
	end

	// shifting slot array: insert opens a gap, remove closes one
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
		localparam logic [OCC_W-1:0] SLOT = OCC_W'(g);
		logic [tcpq_pkg::ID_W-1:0] prev_id;
		logic [tcpq_pkg::ID_W-1:0] next_id;
		logic                      prev_fast;
		logic                      next_fast;

		if (g == 0) begin : g_first
			assign prev_id   = '0;
			assign prev_fast = 1'b0;
		end else begin : g_mid
			assign prev_id   = ids_q[g-1];
			assign prev_fast = fast_q[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_end
			assign next_id   = '0;
			assign next_fast = 1'b0;
		end else begin : g_body
			assign next_id   = ids_q[g+1];
			assign next_fast = fast_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				if (SLOT == ipos) begin
					ids_q[g]  <= req_q.ticket_id;
					fast_q[g] <= req_q.express;
				end else if (SLOT > ipos) begin
					ids_q[g]  <= prev_id;
					fast_q[g] <= prev_fast;
				end
			end else if (cmd.remove && (SLOT >= idx_q)) begin
				ids_q[g]  <= next_id;
				fast_q[g] <= next_fast;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			fcnt_q  <= '0;
			idx_q   <= '0;
			batch_q <= '0;
		end else begin
			occ_q <= occ_d;
			if (cmd.insert && req_q.express) begin
				fcnt_q <= fcnt_q + OCC_W'(1);
			end else if (cmd.remove && sel_fast && (fcnt_q != '0)) begin
				fcnt_q <= fcnt_q - OCC_W'(1);
			end
			if (cmd.load) begin
				idx_q   <= '0;
				batch_q <= '0;
			end else begin
				if (cmd.idx_inc) begin
					idx_q <= idx_q + OCC_W'(1);
				end
				if (cmd.remove) begin
					batch_q <= batch_q + BAT_W'(1);
				end
			end
		end
	end

	// result register
	assign take_entry = (cmd.code == tcpq_pkg::ST_SERVED) ||
	                    (cmd.code == tcpq_pkg::ST_CANCELLED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.status      <= cmd.code;
			out_q.served_id   <= take_entry ? sel_id : '0;
			out_q.served_fast <= take_entry ? sel_fast : 1'b0;
			out_q.remaining   <= tcpq_pkg::REM_W'(occ_d);
			out_q.last        <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[rtl/tcpq_ctrl.sv]
// controller state machine sequencing register, call and cancel requests
`default_nettype none

module tcpq_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	input  wire tcpq_pkg::mode_t   in_mode,
	output logic                   in_ready,
	input  wire tcpq_pkg::dp_stat_t stat,
	output tcpq_pkg::ctrl_cmd_t    cmd
);

	tcpq_pkg::state_t state_q;
	tcpq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcpq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.code = tcpq_pkg::ST_REGISTERED;
		unique case (state_q)
			tcpq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (in_mode)
						tcpq_pkg::MODE_REGISTER: state_d = tcpq_pkg::S_REG;
						tcpq_pkg::MODE_CALL:     state_d = tcpq_pkg::S_CALL;
						tcpq_pkg::MODE_CANCEL:   state_d = tcpq_pkg::S_SCAN;
						default:                 state_d = tcpq_pkg::S_IDLE;
					endcase
				end
			end
			tcpq_pkg::S_REG: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					if (stat.full) begin
						cmd.code = tcpq_pkg::ST_FULL;
					end else begin
						cmd.insert = 1'b1;
						cmd.code   = tcpq_pkg::ST_REGISTERED;
					end
					state_d = tcpq_pkg::S_IDLE;
				end
			end
			tcpq_pkg::S_CALL: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.empty) begin
						cmd.code = tcpq_pkg::ST_NONE;
						cmd.last = 1'b1;
						state_d  = tcpq_pkg::S_IDLE;
					end else begin
						cmd.remove = 1'b1;
						cmd.code   = tcpq_pkg::ST_SERVED;
						cmd.last   = stat.batch_last;
						if (stat.batch_last) begin
							state_d = tcpq_pkg::S_IDLE;
						end
					end
				end
			end
			tcpq_pkg::S_SCAN: begin
				priority if (stat.scan_end) begin
					if (stat.out_free) begin
						cmd.emit = 1'b1;
						cmd.code = tcpq_pkg::ST_NOT_FOUND;
						cmd.last = 1'b1;
						state_d  = tcpq_pkg::S_IDLE;
					end
				end else if (stat.match) begin
					if (stat.out_free) begin
						cmd.emit   = 1'b1;
						cmd.remove = 1'b1;
						cmd.code   = tcpq_pkg::ST_CANCELLED;
						cmd.last   = 1'b1;
						state_d    = tcpq_pkg::S_IDLE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			default: begin
				state_d = tcpq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/two_class_priority_queue_top.sv]
// Two-class ticket queue: fast entries ahead of regular ones, FIFO within each class.
// Input channel in_valid/in_ready/in_data carries one request: register, call or cancel.
// Output channel out_valid/out_ready/out_data carries the results of a request in order;
// the last one of a request has last set.
// A request is taken only while the controller is idle; one request is worked at a time.
// Register: one result, issued once the output register is free.
// Call: one served result per cycle while the output register is free, up to BATCH_SIZE results.
// Cancel: the queue is scanned one entry per cycle from the front until the ticket
// matches or the scan reaches the occupancy; then one result is issued.
// Results wait in an output register; a new request can be taken while the last result
// of the previous one still waits there. While a result waits there untaken, the controller
// holds its next result until the register frees.
// Reset empties the queue at once; slot contents are not cleared and need no sweep.
`default_nettype none

module two_class_priority_queue_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int BATCH_SIZE  = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire tcpq_pkg::req_t  in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output tcpq_pkg::rsp_t       out_data
);

	tcpq_pkg::ctrl_cmd_t cmd;
	tcpq_pkg::dp_stat_t  stat;

	tcpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (in_data.mode),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcpq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.BATCH_SIZE  (BATCH_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[rtl/tcpq_checker.sv]
// port-level checker for the two-class priority queue and its bind
`default_nettype none

`include "assert_macros.svh"

module tcpq_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  out_valid,
	input wire                  out_ready,
	input wire tcpq_pkg::rsp_t  out_data
);

	logic stalled;
	logic none_st;
	logic single_st;
	logic no_entry_st;
	logic none_ok;
	logic id_clear;

	assign stalled     = out_valid && !out_ready;
	assign none_st     = out_data.status == tcpq_pkg::ST_NONE;
	assign single_st   = out_data.status != tcpq_pkg::ST_SERVED;
	assign no_entry_st = (out_data.status == tcpq_pkg::ST_REGISTERED) ||
	                     (out_data.status == tcpq_pkg::ST_FULL) ||
	                     (out_data.status == tcpq_pkg::ST_NOT_FOUND);
	assign none_ok     = (out_data.remaining == '0) && out_data.last;
	assign id_clear    = (out_data.served_id == '0) && !out_data.served_fast;

	`TCPQ_ASSERT_NEXT(a_out_hold, stalled, out_valid, "result dropped while stalled")
	`TCPQ_ASSERT_NEXT(a_out_stable, stalled, $stable(out_data), "stalled result changed")
	`TCPQ_ASSERT_NOW(a_none_empty, out_valid && none_st, none_ok, "none served on nonempty queue")
	`TCPQ_ASSERT_NOW(a_single_last, out_valid && single_st, out_data.last, "single result without last")
	`TCPQ_ASSERT_NOW(a_reg_no_id, out_valid && no_entry_st, id_clear, "id reported without entry")

endmodule

bind two_class_priority_queue_top tcpq_checker u_tcpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the two-class priority queue with cancel
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH = 16;
	localparam int BATCH_SIZE  = 4;
	localparam int RANDOM_ITEMS = 230;
	localparam int PLAN_ROWS = 14;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [tcpq_pkg::ID_W-1:0] id;
		logic                      fast;
	} slot_t;

	typedef struct packed {
		tcpq_pkg::req_t req;
		logic [4:0]     reps;
		logic           typed;
		tcpq_pkg::rsp_t want;
	} plan_row_t;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	tcpq_pkg::req_t in_data;
	logic           out_valid;
	logic           out_ready = 1'b0;
	tcpq_pkg::rsp_t out_data;

	slot_t          line_q[$];
	int             fast_ahead;
	tcpq_pkg::rsp_t expected_rsp[$];
	int             errors;
	int             idle_cycles;
	int             stall_left;
	bit             calm;
	bit             fill_phase;

	two_class_priority_queue_top #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.BATCH_SIZE (BATCH_SIZE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic tcpq_pkg::req_t rq(tcpq_pkg::mode_t m,
			logic [tcpq_pkg::ID_W-1:0] id, logic f);
		tcpq_pkg::req_t r;
		r.mode      = m;
		r.ticket_id = id;
		r.express   = f;
		return r;
	endfunction

	function automatic tcpq_pkg::rsp_t result_of(tcpq_pkg::status_t st,
			logic [tcpq_pkg::ID_W-1:0] id, logic f, int rem, logic l);
		tcpq_pkg::rsp_t r;
		r.status      = st;
		r.served_id   = id;
		r.served_fast = f;
		r.remaining   = tcpq_pkg::REM_W'(rem);
		r.last        = l;
		return r;
	endfunction

	function automatic int serve_request(tcpq_pkg::req_t r);
		int    pos;
		int    hit;
		int    n;
		slot_t s;
		n = 0;
		case (r.mode)
			tcpq_pkg::MODE_REGISTER: begin
				if (line_q.size() >= QUEUE_DEPTH) begin
					expected_rsp.push_back(result_of(tcpq_pkg::ST_FULL, '0, 1'b0,
						line_q.size(), 1'b1));
				end else begin
					pos = r.express ? fast_ahead : line_q.size();
					s.id = r.ticket_id;
					s.fast = r.express;
					line_q.insert(pos, s);
					if (r.express)
						fast_ahead++;
					expected_rsp.push_back(result_of(tcpq_pkg::ST_REGISTERED, '0, 1'b0,
						line_q.size(), 1'b1));
				end
				n = 1;
			end
			tcpq_pkg::MODE_CALL: begin
				if (line_q.size() == 0) begin
					expected_rsp.push_back(result_of(tcpq_pkg::ST_NONE, '0, 1'b0, 0, 1'b1));
					n = 1;
				end else begin
					while (n < BATCH_SIZE && line_q.size() > 0) begin
						s = line_q.pop_front();
						if (s.fast)
							fast_ahead--;
						n++;
						expected_rsp.push_back(result_of(tcpq_pkg::ST_SERVED, s.id, s.fast,
							line_q.size(), n == BATCH_SIZE || line_q.size() == 0));
					end
				end
			end
			tcpq_pkg::MODE_CANCEL: begin
				hit = -1;
				for (int i = 0; i < line_q.size(); i++)
					if (hit < 0 && line_q[i].id == r.ticket_id)
						hit = i;
				if (hit >= 0) begin
					s = line_q[hit];
					line_q.delete(hit);
					if (s.fast)
						fast_ahead--;
					expected_rsp.push_back(result_of(tcpq_pkg::ST_CANCELLED, r.ticket_id,
						s.fast, line_q.size(), 1'b1));
				end else begin
					expected_rsp.push_back(result_of(tcpq_pkg::ST_NOT_FOUND, '0, 1'b0,
						line_q.size(), 1'b1));
				end
				n = 1;
			end
			default: n = 0;
		endcase
		return n;
	endfunction

	function automatic plan_row_t plan_row(int i);
		plan_row_t p;
		p = '0;
		p.reps = 5'd1;
		case (i)
			0: begin
				p.req = rq(tcpq_pkg::MODE_CALL, 16'h0000, 1'b0);
				p.typed = 1'b1;
				p.want = result_of(tcpq_pkg::ST_NONE, '0, 1'b0, 0, 1'b1);
			end
			1: begin
				p.req = rq(tcpq_pkg::MODE_CANCEL, 16'h0000, 1'b0);
				p.typed = 1'b1;
				p.want = result_of(tcpq_pkg::ST_NOT_FOUND, '0, 1'b0, 0, 1'b1);
			end
			2: p.req = rq(tcpq_pkg::MODE_UNUSED, 16'hffff, 1'b1);
			3: begin
				p.req = rq(tcpq_pkg::MODE_REGISTER, 16'h0001, 1'b1);
				p.typed = 1'b1;
				p.want = result_of(tcpq_pkg::ST_REGISTERED, '0, 1'b0, 1, 1'b1);
			end
			4: begin
				p.req = rq(tcpq_pkg::MODE_REGISTER, 16'hffff, 1'b0);
				p.typed = 1'b1;
				p.want = result_of(tcpq_pkg::ST_REGISTERED, '0, 1'b0, 2, 1'b1);
			end
			5: begin
				p.req = rq(tcpq_pkg::MODE_REGISTER, 16'h0000, 1'b1);
				p.typed = 1'b1;
				p.want = result_of(tcpq_pkg::ST_REGISTERED, '0, 1'b0, 3, 1'b1);
			end
			6: begin
				p.req = rq(tcpq_pkg::MODE_REGISTER, 16'h8000, 1'b1);
				p.reps = 5'd6;
			end
			7: begin
				p.req = rq(tcpq_pkg::MODE_REGISTER, 16'h0100, 1'b0);
				p.reps = 5'd7;
			end
			8: begin
				p.req = rq(tcpq_pkg::MODE_REGISTER, 16'h7777, 1'b1);
				p.typed = 1'b1;
				p.want = result_of(tcpq_pkg::ST_FULL, '0, 1'b0, 16, 1'b1);
			end
			9: begin
				p.req = rq(tcpq_pkg::MODE_CANCEL, 16'h0001, 1'b0);
				p.typed = 1'b1;
				p.want = result_of(tcpq_pkg::ST_CANCELLED, 16'h0001, 1'b1, 15, 1'b1);
			end
			10: begin
				p.req = rq(tcpq_pkg::MODE_CANCEL, 16'h0106, 1'b1);
				p.typed = 1'b1;
				p.want = result_of(tcpq_pkg::ST_CANCELLED, 16'h0106, 1'b0, 14, 1'b1);
			end
			11: begin
				p.req = rq(tcpq_pkg::MODE_CANCEL, 16'h1234, 1'b0);
				p.typed = 1'b1;
				p.want = result_of(tcpq_pkg::ST_NOT_FOUND, '0, 1'b0, 14, 1'b1);
			end
			12: begin
				p.req = rq(tcpq_pkg::MODE_CALL, 16'hffff, 1'b1);
				p.reps = 5'd4;
			end
			default: begin
				p.req = rq(tcpq_pkg::MODE_CALL, 16'h0000, 1'b0);
				p.typed = 1'b1;
				p.want = result_of(tcpq_pkg::ST_NONE, '0, 1'b0, 0, 1'b1);
			end
		endcase
		return p;
	endfunction

	task automatic send_request(tcpq_pkg::req_t r, bit typed, tcpq_pkg::rsp_t want);
		int n;
		int gap;
		in_valid <= 1'b1;
		in_data  <= r;
		do
			@(posedge clk);
		while (!in_ready);
		n = serve_request(r);
		if (typed) begin
			repeat (n) void'(expected_rsp.pop_back());
			expected_rsp.push_back(want);
		end
		if (calm)
			gap = 0;
		else if ($urandom_range(0, 9) < 5)
			gap = 0;
		else if ($urandom_range(0, 9) < 9)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic tcpq_pkg::req_t random_request();
		tcpq_pkg::req_t r;
		int             pick;
		pick = $urandom_range(0, 99);
		r.express = 1'($urandom_range(0, 1));
		r.ticket_id = ($urandom_range(0, 1) == 1)
			? tcpq_pkg::ID_W'($urandom_range(0, 65535))
			: tcpq_pkg::ID_W'($urandom_range(0, 7));
		if (pick < (fill_phase ? 65 : 20))
			r.mode = tcpq_pkg::MODE_REGISTER;
		else if (pick < (fill_phase ? 75 : 65))
			r.mode = tcpq_pkg::MODE_CALL;
		else if (pick < 95) begin
			r.mode = tcpq_pkg::MODE_CANCEL;
			if (line_q.size() > 0 && $urandom_range(0, 9) < 7)
				r.ticket_id = line_q[$urandom_range(0, line_q.size() - 1)].id;
		end else
			r.mode = tcpq_pkg::MODE_UNUSED;
		return r;
	endfunction

	task automatic report(string field, int unsigned want, int unsigned got);
		$display("%0t %s expected %0h actual %0h", $time, field, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("two_class_priority_queue_top: mismatch");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t unexpected result expected none actual %h", $time, out_data);
					errors++;
				end else begin
					tcpq_pkg::rsp_t exp_r;
					exp_r = expected_rsp.pop_front();
					if (out_data.status !== exp_r.status)
						report("status", exp_r.status, out_data.status);
					if (out_data.served_id !== exp_r.served_id)
						report("served_id", exp_r.served_id, out_data.served_id);
					if (out_data.served_fast !== exp_r.served_fast)
						report("served_fast", exp_r.served_fast, out_data.served_fast);
					if (out_data.remaining !== exp_r.remaining)
						report("remaining", exp_r.remaining, out_data.remaining);
					if (out_data.last !== exp_r.last)
						report("last", exp_r.last, out_data.last);
				end
			end
			if (calm) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 9) < 7) begin
				out_ready <= 1'b1;
			end else begin
				stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
					: $urandom_range(9, 29);
				out_ready <= 1'b0;
			end
		end
	end

	initial begin
		plan_row_t      p;
		tcpq_pkg::req_t r;
		int             counted;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		errors = 0;
		idle_cycles = 0;
		stall_left = 0;
		fast_ahead = 0;
		calm = 1'b0;
		fill_phase = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			p = plan_row(i);
			for (int k = 0; k < p.reps; k++) begin
				r = p.req;
				r.ticket_id = r.ticket_id + tcpq_pkg::ID_W'(k);
				send_request(r, p.typed, p.want);
			end
		end

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if (counted % 20 == 0) begin
				fill_phase = 1'($urandom_range(0, 1));
				calm = ($urandom_range(0, 3) == 0);
			end
			r = random_request();
			send_request(r, 1'b0, '0);
			if (r.mode != tcpq_pkg::MODE_UNUSED)
				counted++;
		end
		in_valid <= 1'b0;

		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("two_class_priority_queue_top: match");
		else
			$display("two_class_priority_queue_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/tcpq_pkg.sv
rtl/tcpq_datapath.sv
rtl/tcpq_ctrl.sv
rtl/two_class_priority_queue_top.sv
rtl/tcpq_checker.sv
tb/testbench.sv
